>>> design/sirc_ir_frame_decoder_defines.svh
// ---------------------------------------------------------------------------
// SIRC decoder assertion macros
// Shared concurrent assertion forms for the SIRC frame decoder.
// ---------------------------------------------------------------------------
`ifndef SIRC_IR_FRAME_DECODER_DEFINES_SVH
`define SIRC_IR_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SIRCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SIRCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sircd_pkg.sv
// ---------------------------------------------------------------------------
// SIRC decoder package
// Widths, register indexes, reset values and the window compare.
// ---------------------------------------------------------------------------
package sircd_pkg;

   localparam int FRAME_LEN_DEF = 12;
   localparam int TS_W          = 16;
   localparam int CMD_W         = 7;
   localparam int ADDR_W        = 5;
   localparam int WIN_W         = 32;
   localparam int NUM_REGS      = 6;
   localparam int CSR_IDX_W     = 3;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_MARK   = 3'd0,
      REG_START_PERIOD = 3'd1,
      REG_ONE_MARK     = 3'd2,
      REG_ONE_PERIOD   = 3'd3,
      REG_ZERO_MARK    = 3'd4,
      REG_ZERO_PERIOD  = 3'd5
   } csr_index_type;

   localparam logic [WIN_W-1:0] WIN_RESET [NUM_REGS] = '{
      32'd18350280, 32'd23593200, 32'd9175140,
      32'd14418060, 32'd5242920,  32'd9830490
   };

   // A value lies in a window when it is strictly between the low bound
   // (bits 15:0) and the high bound (bits 31:16).
   function automatic logic in_window(input logic [WIN_W-1:0] win,
                                      input logic [TS_W-1:0]  val);
      return (val > win[TS_W-1:0]) && (val < win[WIN_W-1:TS_W]);
   endfunction

endpackage

>>> design/sirc_ir_frame_decoder.sv
// A frame result appears on rsp_ once the beat that ends it has passed the input register and the result register.
// Throughput: one edge beat per cycle unless the decode stage waits; the single decode stage between the
// input register and the result register sets this figure.
// The decode stage waits only while a result is held and rsp_tready is low.
// Reset is synchronous and active high: it empties both registers, clears
// the frame state and loads the reset bounds into the window registers.
// ---------------------------------------------------------------------------
// SIRC infrared frame decoder
// Measures mark widths and fall-to-fall periods from timestamped edge beats,
// decodes the bits of one frame and emits its command and address.
// ---------------------------------------------------------------------------
`include "sirc_ir_frame_decoder_defines.svh"

module sirc_ir_frame_decoder #(
   parameter int FRAME_LEN = sircd_pkg::FRAME_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sircd_pkg::REQ_DATA_W-1:0]     req_tdata,  // timestamp[15:0]
   input  logic                                 req_tuser,  // req_type
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sircd_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // command[6:0], address[11:7]
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sircd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sircd_pkg::WIN_W-1:0]          csr_data
);

   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(FRAME_LEN - 1);
   localparam int TS_W  = sircd_pkg::TS_W;
   localparam int EXT_W = FRAME_LEN + sircd_pkg::CMD_W + sircd_pkg::ADDR_W;

   logic [sircd_pkg::WIN_W-1:0] win_ff [sircd_pkg::NUM_REGS];

   logic                 in_valid_ff;
   logic                 in_type_ff;
   logic [TS_W-1:0]      in_ts_ff;

   logic                 armed_ff, armed_in;
   logic                 in_frame_ff, in_frame_in;
   logic [TS_W-1:0]      last_fall_ff, last_fall_in;
   logic [TS_W-1:0]      mark_width_ff, mark_width_in;
   logic [FRAME_LEN-1:0] frame_bits_ff, frame_bits_in;
   logic [IDX_W-1:0]     bit_count_ff, bit_count_in;

   logic                 rsp_valid_ff;
   logic [sircd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 proc_fire;
   logic                 emit;
   logic [TS_W-1:0]      period;
   logic [TS_W-1:0]      new_mark;
   logic                 is_one;
   logic                 is_zero;
   logic [FRAME_LEN-1:0] frame_out;
   logic [EXT_W-1:0]     frame_ext;

   assign proc_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sircd_pkg::NUM_REGS; i++) begin
            win_ff[i] <= sircd_pkg::WIN_RESET[i];
         end
      end else if (csr_valid && (int'(csr_index) < sircd_pkg::NUM_REGS)) begin
         win_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_ts_ff   <= req_tdata[TS_W-1:0];
      end
   end

   always_comb begin
      period    = in_ts_ff - last_fall_ff;
      new_mark  = in_ts_ff - last_fall_ff;
      is_one    = sircd_pkg::in_window(win_ff[sircd_pkg::REG_ONE_PERIOD], period) &&
                  sircd_pkg::in_window(win_ff[sircd_pkg::REG_ONE_MARK], mark_width_ff);
      is_zero   = sircd_pkg::in_window(win_ff[sircd_pkg::REG_ZERO_PERIOD], period) &&
                  sircd_pkg::in_window(win_ff[sircd_pkg::REG_ZERO_MARK], mark_width_ff);

      armed_in      = armed_ff;
      in_frame_in   = in_frame_ff;
      last_fall_in  = last_fall_ff;
      mark_width_in = mark_width_ff;
      frame_bits_in = frame_bits_ff;
      bit_count_in  = bit_count_ff;
      emit          = 1'b0;
      frame_out     = frame_bits_ff;

      if (proc_fire) begin
         if (!in_type_ff) begin
            if (!in_frame_ff && !armed_ff) begin
               armed_in     = 1'b1;
               last_fall_in = in_ts_ff;
            end else if (!in_frame_ff) begin
               if (sircd_pkg::in_window(win_ff[sircd_pkg::REG_START_PERIOD], period) &&
                   sircd_pkg::in_window(win_ff[sircd_pkg::REG_START_MARK],
                                        mark_width_ff)) begin
                  in_frame_in  = 1'b1;
                  last_fall_in = in_ts_ff;
               end else begin
                  armed_in      = 1'b0;
                  last_fall_in  = '0;
                  mark_width_in = '0;
               end
            end else if ((is_one || is_zero) && (bit_count_ff < LAST_BIT)) begin
               last_fall_in = in_ts_ff;
               if (is_one) begin
                  frame_bits_in[bit_count_ff] = 1'b1;
               end
               bit_count_in = bit_count_ff + 1'b1;
            end else begin
               armed_in      = 1'b0;
               in_frame_in   = 1'b0;
               last_fall_in  = '0;
               mark_width_in = '0;
               frame_bits_in = '0;
               bit_count_in  = '0;
            end
         end else begin
            if (in_frame_ff || armed_ff) begin
               mark_width_in = new_mark;
            end
            if (bit_count_ff == LAST_BIT) begin
               emit = 1'b1;
               frame_out[LAST_BIT] =
                  sircd_pkg::in_window(win_ff[sircd_pkg::REG_ONE_MARK], mark_width_in);
               armed_in      = 1'b0;
               in_frame_in   = 1'b0;
               last_fall_in  = '0;
               mark_width_in = '0;
               frame_bits_in = '0;
               bit_count_in  = '0;
            end
         end
      end

      frame_ext   = {{(sircd_pkg::CMD_W + sircd_pkg::ADDR_W){1'b0}}, frame_out};
      rsp_data_in = '0;
      rsp_data_in[sircd_pkg::CMD_W-1:0] = frame_ext[sircd_pkg::CMD_W-1:0];
      rsp_data_in[sircd_pkg::CMD_W+sircd_pkg::ADDR_W-1:sircd_pkg::CMD_W] =
         frame_ext[sircd_pkg::CMD_W+sircd_pkg::ADDR_W-1:sircd_pkg::CMD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         in_frame_ff   <= 1'b0;
         last_fall_ff  <= '0;
         mark_width_ff <= '0;
         frame_bits_ff <= '0;
         bit_count_ff  <= '0;
      end else begin
         armed_ff      <= armed_in;
         in_frame_ff   <= in_frame_in;
         last_fall_ff  <= last_fall_in;
         mark_width_ff <= mark_width_in;
         frame_bits_ff <= frame_bits_in;
         bit_count_ff  <= bit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `SIRCD_ASSERT_NOW(a_frame_implies_armed, clock, reset,
      in_frame_ff, armed_ff, "in_frame set without armed")
   `SIRCD_ASSERT_NOW(a_idle_state_clear, clock, reset,
      !in_frame_ff, (bit_count_ff == '0) && (frame_bits_ff == '0), "bits held outside a frame")
   `SIRCD_ASSERT_NOW(a_count_bound, clock, reset,
      1'b1, bit_count_ff <= LAST_BIT, "bit count past the frame length")
   `SIRCD_ASSERT_NEXT(a_emit_sets_valid, clock, reset,
      emit, rsp_valid_ff && (bit_count_ff == '0) && !armed_ff, "emitted frame not presented")
   `SIRCD_ASSERT_NOW(a_no_emit_over_held, clock, reset,
      emit, !rsp_valid_ff || rsp_tready, "result overwritten while held")

endmodule

>>> tb/sv/tb_sirc_ir_frame_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SIRC frame decoder testbench
// Sends timestamped edge beats, directed and then mostly well-formed frames
// with random content under several window settings. A scoreboard decodes
// the same beats and checks each emitted command and address in order.
// ---------------------------------------------------------------------------
module tb_sirc_ir_frame_decoder;

   localparam int FRAME_BITS     = sircd_pkg::FRAME_LEN_DEF;
   localparam int TS_W           = sircd_pkg::TS_W;
   localparam int WIN_W          = sircd_pkg::WIN_W;
   localparam int CMD_W          = sircd_pkg::CMD_W;
   localparam int ADDR_W         = sircd_pkg::ADDR_W;
   localparam int NUM_REGS       = sircd_pkg::NUM_REGS;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT        = 900;

   typedef enum bit {EDGE_FALL = 1'b0, EDGE_RISE = 1'b1} edge_kind_type;
   typedef enum int {FRAME_CLEAN, FRAME_CORRUPT, FRAME_OVERRUN, FRAME_CUT} frame_flaw_type;
   typedef logic [WIN_W-1:0] window_set_type [NUM_REGS];

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [CMD_W-1:0]  command;
   } sirc_frame_type;

   class sirc_frame_scoreboard;
      window_set_type        win;
      bit                    armed;
      bit                    in_frame;
      logic [TS_W-1:0]       last_fall;
      logic [TS_W-1:0]       mark_width;
      logic [FRAME_BITS-1:0] frame_bits;
      logic [4:0]            bit_count;
      sirc_frame_type        expected_frames[$];
      int                    errors;

      function new();
         win = sircd_pkg::WIN_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         armed = 1'b0;
         in_frame = 1'b0;
         last_fall = '0;
         mark_width = '0;
         frame_bits = '0;
         bit_count = '0;
      endfunction

      function bit strictly_inside(sircd_pkg::csr_index_type idx, logic [TS_W-1:0] v);
         return (v > win[idx][TS_W-1:0]) && (v < win[idx][WIN_W-1:TS_W]);
      endfunction

      function void write_window(sircd_pkg::csr_index_type idx, logic [WIN_W-1:0] value);
         win[idx] = value;
      endfunction

      function void note_edge(edge_kind_type kind, logic [TS_W-1:0] ts);
         logic [TS_W-1:0]       period;
         logic [FRAME_BITS-1:0] frame;
         bit                    one;
         bit                    zero;
         period = ts - last_fall;
         if (kind == EDGE_FALL) begin
            if (!in_frame && !armed) begin
               armed = 1'b1;
               last_fall = ts;
            end else if (!in_frame) begin
               if (strictly_inside(sircd_pkg::REG_START_PERIOD, period) &&
                   strictly_inside(sircd_pkg::REG_START_MARK, mark_width)) begin
                  in_frame = 1'b1;
                  last_fall = ts;
               end else begin
                  clear_frame();
               end
            end else begin
               one = strictly_inside(sircd_pkg::REG_ONE_PERIOD, period) &&
                     strictly_inside(sircd_pkg::REG_ONE_MARK, mark_width);
               zero = strictly_inside(sircd_pkg::REG_ZERO_PERIOD, period) &&
                      strictly_inside(sircd_pkg::REG_ZERO_MARK, mark_width);
               last_fall = ts;
               if ((one || zero) && bit_count < FRAME_BITS - 1) begin
                  if (one) frame_bits[bit_count] = 1'b1;
                  bit_count = bit_count + 5'd1;
               end else begin
                  clear_frame();
               end
            end
         end else begin
            if (in_frame || armed) mark_width = ts - last_fall;
            if (bit_count == FRAME_BITS - 1) begin
               frame = frame_bits;
               if (strictly_inside(sircd_pkg::REG_ONE_MARK, mark_width)) begin
                  frame[bit_count] = 1'b1;
               end
               expected_frames = {expected_frames, sirc_frame_type'(frame)};
               clear_frame();
            end
         end
      endfunction

      function void check_frame(logic [sircd_pkg::RSP_DATA_W-1:0] data);
         sirc_frame_type want;
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected frame, expected none, actual %h", $time, data);
            errors++;
            return;
         end
         want = expected_frames[0];
         expected_frames.delete(0);
         if (data[CMD_W-1:0] !== want.command) begin
            $display("%0t: command mismatch, expected %h, actual %h",
                     $time, want.command, data[CMD_W-1:0]);
            errors++;
         end
         if (data[CMD_W+ADDR_W-1:CMD_W] !== want.address) begin
            $display("%0t: address mismatch, expected %h, actual %h",
                     $time, want.address, data[CMD_W+ADDR_W-1:CMD_W]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [sircd_pkg::REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                                req_tuser  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [sircd_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [sircd_pkg::CSR_IDX_W-1:0]     csr_index  = sircd_pkg::REG_START_MARK;
   logic [WIN_W-1:0]                    csr_data   = '0;

   sirc_frame_scoreboard sb = new();
   window_set_type       gen_win = sircd_pkg::WIN_RESET;
   int                   send_idle_pct = 23;
   int                   rsp_idle_pct = 53;
   int                   sent_beats = 0;
   int                   req_beats = 0;
   int                   stalled_cycles = 0;
   int                   hold_left = 0;
   bit                   hold_done = 1'b0;
   int                   frame_beats_left = 0;

   sirc_ir_frame_decoder #(.FRAME_LEN(FRAME_BITS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_edge(edge_kind_type'(req_tuser), req_tdata);
            req_beats++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_frame(rsp_tdata);
         if (csr_valid && csr_ready) begin
            sb.write_window(sircd_pkg::csr_index_type'(csr_index), csr_data);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("** sirc_ir_frame_decoder: FAILED **");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && req_beats >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= rsp_idle_pct);
      end
   end

   function automatic logic [TS_W-1:0] pick_inside(logic [WIN_W-1:0] w);
      int lo;
      int hi;
      lo = int'(w[TS_W-1:0]);
      hi = int'(w[WIN_W-1:TS_W]);
      if (hi - lo >= 2) return TS_W'($urandom_range(hi - 1, lo + 1));
      return TS_W'($urandom);
   endfunction

   task automatic send_edge(input edge_kind_type kind, input logic [TS_W-1:0] ts);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= ts;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_beats++;
   endtask

   task automatic frame_beat(input edge_kind_type kind, input logic [TS_W-1:0] ts);
      if (frame_beats_left > 0) begin
         send_edge(kind, ts);
         frame_beats_left--;
      end
   endtask

   task automatic send_frame(input logic [FRAME_BITS-1:0] bits, input frame_flaw_type flaw);
      logic [TS_W-1:0] t;
      logic [TS_W-1:0] mark;
      logic [TS_W-1:0] period;
      int              bad;
      t = TS_W'($urandom);
      bad = (flaw == FRAME_CORRUPT) ? int'($urandom_range(2 * FRAME_BITS + 1, 0)) : -1;
      frame_beats_left = (flaw == FRAME_CUT) ? int'($urandom_range(2 * FRAME_BITS, 1)) :
                         4 * FRAME_BITS;
      mark = pick_inside(gen_win[sircd_pkg::REG_START_MARK]);
      period = pick_inside(gen_win[sircd_pkg::REG_START_PERIOD]);
      if (bad == 0) mark = TS_W'($urandom);
      if (bad == 1) period = TS_W'($urandom);
      frame_beat(EDGE_FALL, t);
      frame_beat(EDGE_RISE, t + mark);
      t = t + period;
      frame_beat(EDGE_FALL, t);
      for (int i = 0; i < FRAME_BITS; i++) begin
         mark = pick_inside(gen_win[bits[i] ? sircd_pkg::REG_ONE_MARK :
                                              sircd_pkg::REG_ZERO_MARK]);
         period = pick_inside(gen_win[bits[i] ? sircd_pkg::REG_ONE_PERIOD :
                                                sircd_pkg::REG_ZERO_PERIOD]);
         if (bad == 2 * i + 2) mark = TS_W'($urandom);
         if (bad == 2 * i + 3) period = TS_W'($urandom);
         frame_beat(EDGE_RISE, t + mark);
         if (i < FRAME_BITS - 1 || flaw == FRAME_OVERRUN) begin
            t = t + period;
            frame_beat(EDGE_FALL, t);
         end
      end
   endtask

   task automatic run_traffic(input int beats);
      int stop_at;
      int pick;
      stop_at = sent_beats + beats;
      while (sent_beats < stop_at) begin
         if (sent_beats < 420) begin
            send_idle_pct = 23;
            rsp_idle_pct = 53;
         end else if (sent_beats < 800) begin
            send_idle_pct = 53;
            rsp_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         pick = $urandom_range(99, 0);
         if (pick < 70) begin
            send_frame(FRAME_BITS'($urandom), FRAME_CLEAN);
         end else if (pick < 80) begin
            send_frame(FRAME_BITS'($urandom), FRAME_CORRUPT);
         end else if (pick < 85) begin
            send_frame(FRAME_BITS'($urandom), FRAME_OVERRUN);
         end else if (pick < 90) begin
            send_frame(FRAME_BITS'($urandom), FRAME_CUT);
         end else begin
            repeat ($urandom_range(4, 1)) begin
               send_edge(edge_kind_type'($urandom_range(1, 0)), TS_W'($urandom));
            end
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_windows(input window_set_type vals);
      for (int i = 0; i < NUM_REGS; i++) begin
         gen_win[i] = vals[i];
         csr_valid <= 1'b1;
         csr_index <= sircd_pkg::csr_index_type'(i);
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [TS_W-1:0] t;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle rise, then a start mark sitting exactly on the low bound.
      send_edge(EDGE_RISE, 16'h0000);
      send_edge(EDGE_FALL, 16'hFFFF);
      send_edge(EDGE_RISE, 16'h00C7);
      send_edge(EDGE_FALL, 16'h012B);

      // An all-ones frame whose timestamps wrap past zero.
      t = 16'hFF00;
      send_edge(EDGE_FALL, t);
      send_edge(EDGE_RISE, t + 16'd201);
      t = t + 16'd359;
      send_edge(EDGE_FALL, t);
      for (int i = 0; i < FRAME_BITS; i++) begin
         send_edge(EDGE_RISE, t + (i[0] ? 16'd139 : 16'd101));
         if (i < FRAME_BITS - 1) begin
            t = t + (i[0] ? 16'd219 : 16'd141);
            send_edge(EDGE_FALL, t);
         end
      end

      // A data bit whose period fits neither window.
      send_edge(EDGE_FALL, 16'd0);
      send_edge(EDGE_RISE, 16'd250);
      send_edge(EDGE_FALL, 16'd300);
      send_edge(EDGE_RISE, 16'd360);
      send_edge(EDGE_FALL, 16'd380);

      run_traffic(330);
      drain();
      program_windows('{{16'd230, 16'd150}, {16'd300, 16'd190}, {16'd110, 16'd70},
                        {16'd170, 16'd110}, {16'd60, 16'd20}, {16'd110, 16'd60}});
      run_traffic(300);
      drain();
      program_windows('{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                        32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF});
      run_traffic(200);
      drain();
      program_windows(sircd_pkg::WIN_RESET);
      run_traffic(320);
      drain();

      if (sb.errors == 0) begin
         $display("** sirc_ir_frame_decoder: PASSED **");
      end else begin
         $display("** sirc_ir_frame_decoder: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/sircd_pkg.sv
design/sirc_ir_frame_decoder.sv
tb/sv/tb_sirc_ir_frame_decoder.sv
